/* rtl/msg_pkg.sv */
`default_nettype none
package msg_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int AMP_W    = 12;
   localparam int OFF_W    = 11;
   localparam int STEP_W   = 32;
   localparam int TIME_W   = 32;
   localparam int DAC_W    = 8;
   localparam int SAMPLE_W = 17;

   typedef enum logic [1:0] {
      WAVE_SINE   = 2'd0,
      WAVE_SQUARE = 2'd1,
      WAVE_SAW    = 2'd2,
      WAVE_TRI    = 2'd3
   } wave_type;

   typedef enum logic [1:0] {
      REG_WAVE_SEL = 2'd0,
      REG_AMP      = 2'd1,
      REG_OFFSET   = 2'd2,
      REG_STEP     = 2'd3
   } reg_idx_type;

   typedef struct packed {
      wave_type           wave_sel;
      logic [AMP_W-1:0]   amp;
      logic [OFF_W-1:0]   offset;
      logic [STEP_W-1:0]  step;
   } cfg_type;

   localparam wave_type          RST_WAVE_SEL = WAVE_SINE;
   localparam logic [AMP_W-1:0]  RST_AMP      = 12'd100;
   localparam logic [OFF_W-1:0]  RST_OFFSET   = 11'd1300;
   localparam logic [STEP_W-1:0] RST_STEP     = 32'd42950;

   localparam logic [11:0] OFFSET_BIAS  = 12'd1000;
   localparam logic [31:0] FULL_SCALE   = 32'd131072000;
   localparam logic [18:0] RECIP_1000   = 19'd268435;
   localparam logic [9:0]  DEC_DIVISOR  = 10'd1000;

   localparam logic [63:0] SIN_C1  = 64'd1686629713;
   localparam logic [63:0] SIN_C3  = 64'd693598668;
   localparam logic [63:0] SIN_C5  = 64'd85569306;
   localparam logic [63:0] SIN_C7  = 64'd5026995;
   localparam logic [63:0] SIN_C9  = 64'd172271;
   localparam logic [63:0] ONE_Q30 = 64'd1073741824;

   // quarter-wave entry in q15, evaluated at elaboration
   function automatic logic [SAMPLE_W-1:0] quarter_sine(input int unsigned idx,
                                                       input int unsigned tbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] p;
      logic [63:0] r;
      x  = 64'(idx) << (30 - tbits);
      x2 = (x * x) >> 30;
      p  = SIN_C9;
      if (x > ONE_Q30) begin
         x  = ONE_Q30;
         x2 = ONE_Q30;
      end
      p = SIN_C7 - ((x2 * p) >> 30);
      p = SIN_C5 - ((x2 * p) >> 30);
      p = SIN_C3 - ((x2 * p) >> 30);
      p = SIN_C1 - ((x2 * p) >> 30);
      r = (x * p) >> 30;
      r = (r + (64'd1 << 14)) >> 15;
      if (r > 64'd32768) begin
         r = 64'd32768;
      end
      return r[SAMPLE_W-1:0];
   endfunction

endpackage
`default_nettype wire

/* rtl/msg_chan_if.sv */
`default_nettype none
interface msg_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_us;

   modport source (output valid, output time_us, input ready);
   modport sink   (input valid, input time_us, output ready);
endinterface

interface msg_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] dac_code;
   logic       clipped;

   modport source (output valid, output dac_code, output clipped, input ready);
   modport sink   (input valid, input dac_code, input clipped, output ready);
endinterface
`default_nettype wire

/* rtl/msg_csr.sv */
`default_nettype none
module msg_csr
   import msg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready,
   output      cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;
   logic        wr_en;

   assign idx        = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_WAVE_SEL: cfg_in.wave_sel = wave_type'(csr_pwdata[1:0]);
            REG_AMP:      cfg_in.amp      = csr_pwdata[AMP_W-1:0];
            REG_OFFSET:   cfg_in.offset   = csr_pwdata[OFF_W-1:0];
            REG_STEP:     cfg_in.step     = csr_pwdata[STEP_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_WAVE_SEL: csr_prdata = {30'd0, cfg_ff.wave_sel};
         REG_AMP:      csr_prdata = {20'd0, cfg_ff.amp};
         REG_OFFSET:   csr_prdata = {21'd0, cfg_ff.offset};
         REG_STEP:     csr_prdata = cfg_ff.step;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_sel <= RST_WAVE_SEL;
         cfg_ff.amp      <= RST_AMP;
         cfg_ff.offset   <= RST_OFFSET;
         cfg_ff.step     <= RST_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/msg_phase.sv */
`default_nettype none
module msg_phase
   import msg_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  valid_in,
   input  wire logic [TIME_W-1:0]     time_us,
   input  wire logic [STEP_W-1:0]     step,
   output      logic                  valid_out,
   output      logic [PHASE_BITS-1:0] phase
);

   logic [63:0]           prod;
   logic [PHASE_BITS-1:0] phase_ff;
   logic                  valid_ff;

   assign prod      = 64'(time_us) * 64'(step);
   assign phase     = phase_ff;
   assign valid_out = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         phase_ff <= prod[PHASE_BITS-1:0];
      end
   end

endmodule
`default_nettype wire

/* rtl/msg_wave.sv */
`default_nettype none
module msg_wave
   import msg_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 8,
   parameter int PHASE_BITS      = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       valid_in,
   input  wire logic [PHASE_BITS-1:0]      phase,
   input  wire wave_type                   wave_sel,
   output      logic                       valid_out,
   output      logic signed [SAMPLE_W-1:0] sample,
   output      logic                       half_scale
);

   localparam int TSIZE    = 1 << SINE_TABLE_BITS;
   localparam int IDX_W    = SINE_TABLE_BITS + 1;
   localparam int ROM_BITS = (TSIZE + 1) * SAMPLE_W;

   function automatic logic [ROM_BITS-1:0] build_rom();
      logic [ROM_BITS-1:0] tbl;
      tbl = '0;
      for (int i = 0; i <= TSIZE; i++) begin
         tbl[i*SAMPLE_W +: SAMPLE_W] = quarter_sine(i, SINE_TABLE_BITS);
      end
      return tbl;
   endfunction

   localparam logic [ROM_BITS-1:0] SINE_ROM = build_rom();

   localparam logic signed [SAMPLE_W-1:0] W_POS = 17'sd32768;
   localparam logic signed [SAMPLE_W-1:0] W_NEG = -17'sd32768;

   logic [1:0]                 quad;
   logic [15:0]                frac;
   logic [SINE_TABLE_BITS-1:0] idx_raw;
   logic [IDX_W-1:0]           idx;
   logic [16:0]                tri_dist;
   logic [17:0]                tri_wide;
   logic signed [SAMPLE_W-1:0] other_in;

   logic                       valid2_ff;
   logic [SAMPLE_W-1:0]        rom_ff;
   logic                       neg_ff;
   wave_type                   sel_ff;
   logic signed [SAMPLE_W-1:0] other_ff;

   logic                       valid3_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] sample_in;
   logic                       half_ff;

   assign quad     = phase[PHASE_BITS-1 -: 2];
   assign frac     = phase[PHASE_BITS-1 -: 16];
   assign idx_raw  = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign idx      = quad[0] ? IDX_W'(TSIZE) - {1'b0, idx_raw} : {1'b0, idx_raw};
   assign tri_dist = frac[15] ? 17'd65536 - {1'b0, frac} : {1'b0, frac};
   assign tri_wide = {tri_dist, 1'b0} - 18'd32768;

   always_comb begin
      case (wave_sel)
         WAVE_SQUARE: other_in = phase[PHASE_BITS-1] ? W_NEG : W_POS;
         WAVE_SAW:    other_in = $signed({1'b0, frac}) - W_POS;
         WAVE_TRI:    other_in = $signed(tri_wide[SAMPLE_W-1:0]);
         default:     other_in = '0;
      endcase
   end

   always_comb begin
      if (sel_ff == WAVE_SINE) begin
         sample_in = neg_ff ? -$signed(rom_ff) : $signed(rom_ff);
      end else begin
         sample_in = other_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (advance) begin
         valid2_ff <= valid_in;
         valid3_ff <= valid2_ff;
      end
   end

   // sine rom with registered read
   always_ff @(posedge clock) begin
      if (advance) begin
         rom_ff    <= SINE_ROM[int'(idx)*SAMPLE_W +: SAMPLE_W];
         neg_ff    <= quad[1];
         sel_ff    <= wave_sel;
         other_ff  <= other_in;
         sample_ff <= sample_in;
         half_ff   <= (sel_ff == WAVE_TRI);
      end
   end

   assign valid_out  = valid3_ff;
   assign sample     = sample_ff;
   assign half_scale = half_ff;

endmodule
`default_nettype wire

/* rtl/msg_scale.sv */
`default_nettype none
module msg_scale
   import msg_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       advance,
   input  wire logic                       valid_in,
   input  wire logic signed [SAMPLE_W-1:0] sample,
   input  wire logic                       half_scale,
   input  wire logic [AMP_W-1:0]           amp,
   input  wire logic [OFF_W-1:0]           offset,
   output      logic                       valid_out,
   output      logic [DAC_W-1:0]           dac_code,
   output      logic                       clipped
);

   // stage 4: amplitude product
   logic               valid4_ff;
   logic signed [29:0] prod_ff;
   logic               half4_ff;
   logic signed [29:0] prod_in;

   // stage 5: offset, saturation test, times 255 over 2^17
   logic               valid5_ff;
   logic [17:0]        m5_ff;
   logic               lo5_ff;
   logic               hi5_ff;
   logic signed [30:0] scaled;
   logic [11:0]        bias_mv;
   logic signed [31:0] n_val;
   logic [27:0]        n_low;
   logic [35:0]        n255;

   // stage 6: reciprocal estimate of the quotient by 1000
   logic               valid6_ff;
   logic [17:0]        m6_ff;
   logic [8:0]         q6_ff;
   logic               lo6_ff;
   logic               hi6_ff;
   logic [36:0]        q_prod;

   // stage 7: correction and output word
   logic               valid7_ff;
   logic [DAC_W-1:0]   dac_ff;
   logic               clip_ff;
   logic [17:0]        rem;
   logic [8:0]         q_fix;
   logic [DAC_W-1:0]   dac_in;

   assign prod_in = $signed({1'b0, amp}) * sample;

   assign scaled  = half4_ff ? 31'(prod_ff) : {prod_ff, 1'b0};
   assign bias_mv = {1'b0, offset} + OFFSET_BIAS;
   assign n_val   = 32'(scaled) + $signed({4'd0, bias_mv, 16'd0});
   assign n_low   = n_val[27:0];
   assign n255    = {n_low, 8'd0} - {8'd0, n_low};

   assign q_prod  = 37'(m5_ff) * 37'(RECIP_1000);

   assign rem     = m6_ff - 18'(q6_ff) * 18'(DEC_DIVISOR);
   assign q_fix   = (rem >= 18'(DEC_DIVISOR)) ? q6_ff + 9'd1 : q6_ff;

   always_comb begin
      if (lo6_ff) begin
         dac_in = '0;
      end else if (hi6_ff) begin
         dac_in = '1;
      end else begin
         dac_in = q_fix[DAC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
         valid6_ff <= 1'b0;
         valid7_ff <= 1'b0;
      end else if (advance) begin
         valid4_ff <= valid_in;
         valid5_ff <= valid4_ff;
         valid6_ff <= valid5_ff;
         valid7_ff <= valid6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff  <= prod_in;
         half4_ff <= half_scale;
         m5_ff    <= n255[34:17];
         lo5_ff   <= n_val < 0;
         hi5_ff   <= n_val > $signed(FULL_SCALE);
         m6_ff    <= m5_ff;
         q6_ff    <= q_prod[36:28];
         lo6_ff   <= lo5_ff;
         hi6_ff   <= hi5_ff;
         dac_ff   <= dac_in;
         clip_ff  <= lo6_ff || hi6_ff;
      end
   end

   assign valid_out = valid7_ff;
   assign dac_code  = dac_ff;
   assign clipped   = clip_ff;

endmodule
`default_nettype wire

/* rtl/multi_waveform_sample_generator.sv */
// an accepted word is registered in turn as phase, table read, sample, amplitude product,
// scaled value, quotient estimate and output word, which presents the result
// throughput: one word per cycle; the seven stages advance together and hold on a stall
// the multipliers for phase, amplitude and the reciprocal divide set the stage count
// reset is synchronous, active high; it empties the pipeline and loads register defaults
`default_nettype none
module multi_waveform_sample_generator
   import msg_pkg::*;
#(
   parameter int SINE_TABLE_BITS = 8,
   parameter int PHASE_BITS      = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   msg_req_if.sink                    req_ch,
   msg_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   cfg_type                    cfg;
   logic                       advance;
   logic                       phase_valid;
   logic [PHASE_BITS-1:0]      phase;
   logic                       wave_valid;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       half_scale;
   logic                       out_valid;

   assign advance      = !out_valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = out_valid;

   msg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   msg_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .valid_in  (req_ch.valid),
      .time_us   (req_ch.time_us),
      .step      (cfg.step),
      .valid_out (phase_valid),
      .phase     (phase)
   );

   msg_wave #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .PHASE_BITS      (PHASE_BITS)
   ) u_wave (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .valid_in   (phase_valid),
      .phase      (phase),
      .wave_sel   (cfg.wave_sel),
      .valid_out  (wave_valid),
      .sample     (sample),
      .half_scale (half_scale)
   );

   msg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .valid_in   (wave_valid),
      .sample     (sample),
      .half_scale (half_scale),
      .amp        (cfg.amp),
      .offset     (cfg.offset),
      .valid_out  (out_valid),
      .dac_code   (rsp_ch.dac_code),
      .clipped    (rsp_ch.clipped)
   );

endmodule
`default_nettype wire
